/* rtl/jsu_pkg.sv */
// jsu_pkg: types, codes and helper functions of the JSON string unescaper
// used by jsu_decode, json_string_unescape_utf8 and the bench; depends on nothing

package jsu_pkg;

    // decoding phase, one-hot
    typedef enum logic [6:0] {
        PH_QUOTE   = 7'b0000001,
        PH_BODY    = 7'b0000010,
        PH_ESC     = 7'b0000100,
        PH_HEX_HI  = 7'b0001000,
        PH_SUR_BSL = 7'b0010000,
        PH_SUR_U   = 7'b0100000,
        PH_HEX_LO  = 7'b1000000
    } t_phase;

    // string status codes
    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_OK      = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_BADESC  = 3'd3,
        ST_BADHEX  = 3'd4,
        ST_BADSUR  = 3'd5,
        ST_CTRL    = 3'd6
    } t_status;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // top six bits of high and low surrogate units
    localparam logic [5:0] SUR_HI_TAG = 6'b110110;
    localparam logic [5:0] SUR_LO_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // decoder state
    typedef struct packed {
        t_phase      phase;
        logic [15:0] hex_value;
        logic [1:0]  digits;
        logic [9:0]  hi_sur;
    } t_state;

    localparam t_state STATE_RESET = '{phase: PH_QUOTE, hex_value: 16'h0000,
                                       digits: 2'd0, hi_sur: 10'h000};

    // group of results caused by one input request
    typedef struct packed {
        logic            valid;
        logic            is_status;
        t_status         status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_group;

    // utf-8 byte sequence, bytes[0] goes out first
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_utf8;

    // hex digit value, bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // utf-8 encoding of a code point below 0x200000
    function automatic t_utf8 encode_utf8(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

endpackage

/* rtl/jsu_decode.sv */
// jsu_decode: next decoder state and result group for one input byte
// depends on jsu_pkg

module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_eod,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_group o_grp
);

    logic [7:0]       c;
    logic [4:0]       nib;
    logic [15:0]      hv_new;
    logic [20:0]      cp_pair;
    jsu_pkg::t_status err;
    jsu_pkg::t_utf8   enc_hi;
    jsu_pkg::t_utf8   enc_pair;
    jsu_pkg::t_state  nxt;
    jsu_pkg::t_group  grp;

    // end of data acts as a nul byte
    assign c       = i_eod ? jsu_pkg::CH_NUL : i_byte;
    assign nib     = jsu_pkg::hex_nibble(c);
    assign hv_new  = {i_state.hex_value[11:0], nib[3:0]};
    assign cp_pair = {1'b0, i_state.hi_sur, hv_new[9:0]} + jsu_pkg::SUPP_BASE;
    assign enc_hi  = jsu_pkg::encode_utf8({5'd0, hv_new});
    assign enc_pair = jsu_pkg::encode_utf8(cp_pair);

    // phase update and byte emission
    always_comb begin
        nxt = i_state;
        grp = '0;
        grp.status = jsu_pkg::ST_BUSY;
        err = jsu_pkg::ST_BUSY;
        case (i_state.phase)
            jsu_pkg::PH_QUOTE: begin
                if (c == jsu_pkg::CH_QUOTE) nxt.phase = jsu_pkg::PH_BODY;
                else err = jsu_pkg::ST_BADESC;
            end
            jsu_pkg::PH_BODY: begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    err = jsu_pkg::ST_OK;
                end else if (c == jsu_pkg::CH_BSL) begin
                    nxt.phase = jsu_pkg::PH_ESC;
                end else if (c == jsu_pkg::CH_NUL) begin
                    err = jsu_pkg::ST_NOQUOTE;
                end else if (c < jsu_pkg::CH_SPACE) begin
                    err = jsu_pkg::ST_CTRL;
                end else begin
                    grp.valid    = 1'b1;
                    grp.bytes[0] = c;
                end
            end
            jsu_pkg::PH_ESC: begin
                nxt.phase = jsu_pkg::PH_BODY;
                grp.valid = 1'b1;
                case (c)
                    jsu_pkg::CH_QUOTE: grp.bytes[0] = c;
                    jsu_pkg::CH_BSL:   grp.bytes[0] = c;
                    jsu_pkg::CH_SLASH: grp.bytes[0] = c;
                    jsu_pkg::CH_LC_B:  grp.bytes[0] = jsu_pkg::CH_BS;
                    jsu_pkg::CH_LC_F:  grp.bytes[0] = jsu_pkg::CH_FF;
                    jsu_pkg::CH_LC_N:  grp.bytes[0] = jsu_pkg::CH_LF;
                    jsu_pkg::CH_LC_R:  grp.bytes[0] = jsu_pkg::CH_CR;
                    jsu_pkg::CH_LC_T:  grp.bytes[0] = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_LC_U: begin
                        grp.valid     = 1'b0;
                        nxt.phase     = jsu_pkg::PH_HEX_HI;
                        nxt.hex_value = 16'h0000;
                        nxt.digits    = 2'd0;
                    end
                    default: begin
                        grp.valid = 1'b0;
                        err       = jsu_pkg::ST_BADESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
                if (!nib[4]) begin
                    err = jsu_pkg::ST_BADHEX;
                end else begin
                    nxt.hex_value = hv_new;
                    if (i_state.digits != 2'd3) begin
                        nxt.digits = i_state.digits + 2'd1;
                    end else begin
                        nxt.digits = 2'd0;
                        if (i_state.phase == jsu_pkg::PH_HEX_HI) begin
                            // high surrogate waits for its partner
                            if (hv_new[15:10] == jsu_pkg::SUR_HI_TAG) begin
                                nxt.hi_sur = hv_new[9:0];
                                nxt.phase  = jsu_pkg::PH_SUR_BSL;
                            end else begin
                                grp.valid    = 1'b1;
                                grp.bytes    = enc_hi.bytes;
                                grp.last_idx = enc_hi.last_idx;
                                nxt.phase    = jsu_pkg::PH_BODY;
                            end
                        end else begin
                            if (hv_new[15:10] != jsu_pkg::SUR_LO_TAG) begin
                                err = jsu_pkg::ST_BADSUR;
                            end else begin
                                grp.valid    = 1'b1;
                                grp.bytes    = enc_pair.bytes;
                                grp.last_idx = enc_pair.last_idx;
                                nxt.phase    = jsu_pkg::PH_BODY;
                            end
                        end
                    end
                end
            end
            jsu_pkg::PH_SUR_BSL: begin
                if (c == jsu_pkg::CH_BSL) nxt.phase = jsu_pkg::PH_SUR_U;
                else err = jsu_pkg::ST_BADSUR;
            end
            jsu_pkg::PH_SUR_U: begin
                if (c == jsu_pkg::CH_LC_U) begin
                    nxt.phase     = jsu_pkg::PH_HEX_LO;
                    nxt.hex_value = 16'h0000;
                    nxt.digits    = 2'd0;
                end else begin
                    err = jsu_pkg::ST_BADSUR;
                end
            end
            default: nxt.phase = jsu_pkg::PH_QUOTE;
        endcase

        // string ended: report status and restart
        if (err != jsu_pkg::ST_BUSY) begin
            nxt           = jsu_pkg::STATE_RESET;
            grp           = '0;
            grp.valid     = 1'b1;
            grp.is_status = 1'b1;
            grp.status    = err;
        end
    end

    assign o_state = nxt;
    assign o_grp   = grp;

endmodule

/* rtl/json_string_unescape_utf8.sv */
// json_string_unescape_utf8: top level of the JSON string unescaper
// depends on jsu_pkg and jsu_decode
//
// Takes the raw bytes of a quoted JSON string, opening quote first, one byte
// per request, and returns the UTF-8 bytes of its value followed by one
// status result when the string ends (ok or an error). A byte is decoded in
// the cycle it is accepted and its results (zero to four) go into a result
// register that drains one result per cycle while the receiver is ready.
// Input is taken every cycle while the receiver is ready and each byte yields
// at most one result; a byte that yields more results (a \u escape gives up
// to four) holds off the next byte until its last result is taken, which is
// set by the single result register. A byte with no result holds nothing off.

module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_data
    // result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [3:0] o_m_tuser,   // [0] has_byte, [3:1] status
    output logic       o_m_tlast    // last
);

    jsu_pkg::t_state  r_st;
    jsu_pkg::t_state  n_st;
    jsu_pkg::t_group  n_grp;
    logic             r_vld;
    logic             r_is_status;
    jsu_pkg::t_status r_status;
    logic [1:0]       r_left;
    logic [3:0][7:0]  r_bytes;
    logic             in_acc;
    logic             out_acc;
    logic             load;

    // byte decoder
    jsu_decode u_decode (
        .i_state (r_st),
        .i_byte  (i_s_tdata),
        .i_eod   (i_s_tlast),
        .o_state (n_st),
        .o_grp   (n_grp)
    );

    // handshake
    assign o_s_tready = !r_vld || (i_m_tready && (r_left == 2'd0));
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_vld && i_m_tready;
    assign load       = in_acc && n_grp.valid;

    // decoder state and result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= jsu_pkg::STATE_RESET;
            r_vld       <= 1'b0;
            r_left      <= 2'd0;
            r_is_status <= 1'b0;
            r_status    <= jsu_pkg::ST_BUSY;
        end else begin
            if (in_acc) begin
                r_st <= n_st;
            end
            if (load) begin
                r_vld       <= 1'b1;
                r_left      <= n_grp.last_idx;
                r_is_status <= n_grp.is_status;
                r_status    <= n_grp.status;
            end else if (out_acc) begin
                if (r_left == 2'd0) r_vld <= 1'b0;
                else r_left <= r_left - 2'd1;
            end
        end
    end

    // result bytes, shifted down as they go out
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_grp.bytes;
        end else if (out_acc) begin
            r_bytes <= {8'h00, r_bytes[3:1]};
        end
    end

    // result outputs
    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_is_status ? 8'h00 : r_bytes[0];
    assign o_m_tuser  = {r_status, !r_is_status};
    assign o_m_tlast  = (r_left == 2'd0);

    // new group only loads as the previous one finishes
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_vld) |-> (out_acc && o_m_tlast))
        else $error("request accepted over a pending result group");

    // a status result stands alone
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_is_status) |-> (r_left == 2'd0 && r_status != jsu_pkg::ST_BUSY))
        else $error("status result inside a byte group");

    // byte results carry busy status
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_is_status) |-> (r_status == jsu_pkg::ST_BUSY))
        else $error("byte result with final status");

    // a taken result that is not the last leaves the group valid
    a_group_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_m_tlast) |=> (r_vld && r_left == $past(r_left) - 2'd1))
        else $error("result group lost before its last result");

    // waiting for a quote means no escape state left over
    a_quote_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == jsu_pkg::PH_QUOTE) |-> (r_st.digits == 2'd0 && r_st.hi_sur == 10'h000))
        else $error("escape state left after string end");

endmodule

/* tb/json_string_unescape_utf8_tb.sv */
// json_string_unescape_utf8_tb: self-checking bench for the JSON string unescaper
// sends raw string bytes, predicts the decoded UTF-8 bytes and status, checks each result
// depends on jsu_pkg and json_string_unescape_utf8

module json_string_unescape_utf8_tb;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 300;
    localparam int FLOOD_BYTES  = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    // one decoded result as it should leave the block
    typedef struct {
        logic [7:0]       data;
        logic             has_byte;
        jsu_pkg::t_status status;
        logic             last;
    } t_decoded;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] in_byte
    logic       i_s_tlast;   // end_of_data
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic [3:0] o_m_tuser;   // [0] has_byte, [3:1] status
    logic       o_m_tlast;   // last

    // decoder state mirrored by the bench
    jsu_pkg::t_phase dec_phase;
    logic [15:0]     dec_hex;
    logic [1:0]      dec_digits;
    logic [9:0]      dec_hi_sur;

    t_decoded decoded_q[$];
    int       error_count;
    int       bytes_sent;
    int       cycle_count;
    int       rx_hold;
    int       rx_gap;
    bit       gaps_on;

    json_string_unescape_utf8 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ascii hex digit, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // predict the results one accepted byte causes
    task automatic unescape_byte(input logic [7:0] raw, input logic eod);
        logic [7:0]       c;
        logic [7:0]       utf8 [4];
        int               nb;
        jsu_pkg::t_status st;
        logic [4:0]       digit;
        logic             to_encode;
        logic [20:0]      cp;
        t_decoded         r;
        c = eod ? jsu_pkg::CH_NUL : raw;
        nb = 0;
        st = jsu_pkg::ST_BUSY;
        to_encode = 1'b0;
        cp = '0;
        case (dec_phase)
            jsu_pkg::PH_QUOTE: begin
                if (c == jsu_pkg::CH_QUOTE) dec_phase = jsu_pkg::PH_BODY;
                else st = jsu_pkg::ST_BADESC;
            end
            jsu_pkg::PH_BODY: begin
                if (c == jsu_pkg::CH_QUOTE) st = jsu_pkg::ST_OK;
                else if (c == jsu_pkg::CH_BSL) dec_phase = jsu_pkg::PH_ESC;
                else if (c == jsu_pkg::CH_NUL) st = jsu_pkg::ST_NOQUOTE;
                else if (c < jsu_pkg::CH_SPACE) st = jsu_pkg::ST_CTRL;
                else begin
                    utf8[0] = c;
                    nb = 1;
                end
            end
            jsu_pkg::PH_ESC: begin
                dec_phase = jsu_pkg::PH_BODY;
                nb = 1;
                case (c)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: utf8[0] = c;
                    jsu_pkg::CH_LC_B: utf8[0] = jsu_pkg::CH_BS;
                    jsu_pkg::CH_LC_F: utf8[0] = jsu_pkg::CH_FF;
                    jsu_pkg::CH_LC_N: utf8[0] = jsu_pkg::CH_LF;
                    jsu_pkg::CH_LC_R: utf8[0] = jsu_pkg::CH_CR;
                    jsu_pkg::CH_LC_T: utf8[0] = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_LC_U: begin
                        nb = 0;
                        dec_phase = jsu_pkg::PH_HEX_HI;
                        dec_hex = '0;
                        dec_digits = '0;
                    end
                    default: begin
                        nb = 0;
                        st = jsu_pkg::ST_BADESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
                // bit 4 marks a valid digit; letters map through their low nibble
                if (c >= 8'h30 && c <= 8'h39) digit = {1'b1, c[3:0]};
                else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                    digit = {1'b1, c[3:0] + 4'd9};
                else digit = 5'd0;
                if (!digit[4]) st = jsu_pkg::ST_BADHEX;
                else begin
                    dec_hex = {dec_hex[11:0], digit[3:0]};
                    if (dec_digits != 2'd3) dec_digits = dec_digits + 2'd1;
                    else begin
                        dec_digits = 2'd0;
                        if (dec_phase == jsu_pkg::PH_HEX_HI &&
                            dec_hex[15:10] == jsu_pkg::SUR_HI_TAG) begin
                            dec_hi_sur = dec_hex[9:0];
                            dec_phase = jsu_pkg::PH_SUR_BSL;
                        end else if (dec_phase == jsu_pkg::PH_HEX_HI) begin
                            cp = {5'd0, dec_hex};
                            to_encode = 1'b1;
                            dec_phase = jsu_pkg::PH_BODY;
                        end else if (dec_hex[15:10] != jsu_pkg::SUR_LO_TAG) begin
                            st = jsu_pkg::ST_BADSUR;
                        end else begin
                            cp = {1'b0, dec_hi_sur, dec_hex[9:0]} + jsu_pkg::SUPP_BASE;
                            to_encode = 1'b1;
                            dec_phase = jsu_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsu_pkg::PH_SUR_BSL: begin
                if (c == jsu_pkg::CH_BSL) dec_phase = jsu_pkg::PH_SUR_U;
                else st = jsu_pkg::ST_BADSUR;
            end
            jsu_pkg::PH_SUR_U: begin
                if (c == jsu_pkg::CH_LC_U) begin
                    dec_phase = jsu_pkg::PH_HEX_LO;
                    dec_hex = '0;
                    dec_digits = '0;
                end else begin
                    st = jsu_pkg::ST_BADSUR;
                end
            end
            default: dec_phase = jsu_pkg::PH_QUOTE;
        endcase

        // utf-8 byte sequence of a completed code point
        if (to_encode) begin
            if (cp < 21'h80) begin
                utf8[0] = cp[7:0];
                nb = 1;
            end else if (cp < 21'h800) begin
                utf8[0] = 8'hC0 | cp[10:6];
                utf8[1] = 8'h80 | cp[5:0];
                nb = 2;
            end else if (cp < 21'h10000) begin
                utf8[0] = 8'hE0 | cp[15:12];
                utf8[1] = 8'h80 | cp[11:6];
                utf8[2] = 8'h80 | cp[5:0];
                nb = 3;
            end else begin
                utf8[0] = 8'hF0 | cp[20:18];
                utf8[1] = 8'h80 | cp[17:12];
                utf8[2] = 8'h80 | cp[11:6];
                utf8[3] = 8'h80 | cp[5:0];
                nb = 4;
            end
        end

        // string ended: back to waiting for a quote
        if (st != jsu_pkg::ST_BUSY) begin
            dec_phase = jsu_pkg::PH_QUOTE;
            dec_hex = '0;
            dec_digits = '0;
            dec_hi_sur = '0;
        end

        for (int k = 0; k < nb; k++) begin
            r.data = utf8[k];
            r.has_byte = 1'b1;
            r.status = jsu_pkg::ST_BUSY;
            r.last = (k == nb - 1) && (st == jsu_pkg::ST_BUSY);
            decoded_q = {decoded_q, r};
        end
        if (st != jsu_pkg::ST_BUSY) begin
            r.data = 8'h00;
            r.has_byte = 1'b0;
            r.status = st;
            r.last = 1'b1;
            decoded_q = {decoded_q, r};
        end
    endtask

    // offer one request, wait for it to be taken, then maybe idle
    task automatic send_byte(input logic [7:0] b, input logic eod = 1'b0);
        int gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= eod;
        do @(posedge i_clk); while (!o_s_tready);
        unescape_byte(b, eod);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // \u escape with four hex digits
    task automatic send_unit(input logic [15:0] u);
        send_byte(jsu_pkg::CH_BSL);
        send_byte(jsu_pkg::CH_LC_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(u[i*4 +: 4]));
    endtask

    // sender stops until every predicted result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    // up to three hex digits after \u, then a non-digit or end of data
    task automatic send_broken_hex();
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom)));
        if ($urandom_range(0, 3) == 0) begin
            send_byte(8'($urandom), 1'b1);
        end else begin
            do b = 8'($urandom);
            while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                   (b >= 8'h61 && b <= 8'h66));
            send_byte(b);
        end
    endtask

    // one well-formed piece of a string body
    task automatic send_element();
        logic [7:0]  b;
        logic [15:0] u;
        logic [9:0]  hi;
        logic [9:0]  lo;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do b = 8'($urandom_range(8'h20, 8'hFF));
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
                send_byte(b);
            end
            4, 5: begin
                send_byte(jsu_pkg::CH_BSL);
                case ($urandom_range(0, 7))
                    0: send_byte(jsu_pkg::CH_QUOTE);
                    1: send_byte(jsu_pkg::CH_BSL);
                    2: send_byte(jsu_pkg::CH_SLASH);
                    3: send_byte(jsu_pkg::CH_LC_B);
                    4: send_byte(jsu_pkg::CH_LC_F);
                    5: send_byte(jsu_pkg::CH_LC_N);
                    6: send_byte(jsu_pkg::CH_LC_R);
                    default: send_byte(jsu_pkg::CH_LC_T);
                endcase
            end
            6: begin
                // bmp code point, often at a utf-8 length boundary
                case ($urandom_range(0, 15))
                    0: u = 16'h0000;
                    1: u = 16'h007F;
                    2: u = 16'h0080;
                    3: u = 16'h07FF;
                    4: u = 16'h0800;
                    5: u = 16'hD7FF;
                    6: u = 16'hE000;
                    7: u = 16'hFFFF;
                    default: u = 16'($urandom);
                endcase
                if (u[15:10] == jsu_pkg::SUR_HI_TAG) u[10] = 1'b1;
                send_unit(u);
            end
            7: begin
                // lone low surrogate goes through as three bytes
                send_unit({jsu_pkg::SUR_LO_TAG, 10'($urandom)});
            end
            default: begin
                hi = ($urandom_range(0, 7) == 0) ? 10'h000 : 10'($urandom);
                lo = ($urandom_range(0, 7) == 0) ? 10'h3FF : 10'($urandom);
                send_unit({jsu_pkg::SUR_HI_TAG, hi});
                send_unit({jsu_pkg::SUR_LO_TAG, lo});
            end
        endcase
    endtask

    // a way for an open string to go wrong
    task automatic send_fault();
        logic [7:0] b;
        logic [15:0] u;
        case ($urandom_range(0, 8))
            0: send_byte(8'($urandom_range(1, 8'h1F)));
            1: send_byte(jsu_pkg::CH_NUL);
            2: send_byte(8'($urandom), 1'b1);
            3: begin
                send_byte(jsu_pkg::CH_BSL);
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(8'($urandom), 1'b1);
                end else begin
                    do b = 8'($urandom);
                    while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL ||
                           b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_LC_B ||
                           b == jsu_pkg::CH_LC_F || b == jsu_pkg::CH_LC_N ||
                           b == jsu_pkg::CH_LC_R || b == jsu_pkg::CH_LC_T ||
                           b == jsu_pkg::CH_LC_U);
                    send_byte(b);
                end
            end
            4: begin
                send_byte(jsu_pkg::CH_BSL);
                send_byte(jsu_pkg::CH_LC_U);
                send_broken_hex();
            end
            5: begin
                // high surrogate without a following backslash
                send_unit({jsu_pkg::SUR_HI_TAG, 10'($urandom)});
                do b = 8'($urandom); while (b == jsu_pkg::CH_BSL);
                send_byte(b, $urandom_range(0, 3) == 0);
            end
            6: begin
                // backslash after a high surrogate, but no u
                send_unit({jsu_pkg::SUR_HI_TAG, 10'($urandom)});
                send_byte(jsu_pkg::CH_BSL);
                do b = 8'($urandom); while (b == jsu_pkg::CH_LC_U);
                send_byte(b, $urandom_range(0, 3) == 0);
            end
            7: begin
                // second unit outside the low surrogate range
                send_unit({jsu_pkg::SUR_HI_TAG, 10'($urandom)});
                u = 16'($urandom);
                if (u[15:10] == jsu_pkg::SUR_LO_TAG) u[10] = 1'b0;
                send_unit(u);
            end
            default: begin
                send_unit({jsu_pkg::SUR_HI_TAG, 10'($urandom)});
                send_byte(jsu_pkg::CH_BSL);
                send_byte(jsu_pkg::CH_LC_U);
                send_broken_hex();
            end
        endcase
    endtask

    // one string: mostly well formed, some broken, a little noise
    task automatic send_random_string();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            b = 8'($urandom);
            if (b == jsu_pkg::CH_QUOTE) b = ~b;
            send_byte(b, $urandom_range(0, 3) == 0);
        end else if (kind < 8) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end else begin
            send_byte(jsu_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) send_element();
            if (kind < 72) send_byte(jsu_pkg::CH_QUOTE);
            else send_fault();
        end
    endtask

    // edge values and the special cases, one short string each
    task automatic test_directed();
        // first byte not a quote, then end of data in its place
        send_byte(8'h78);
        send_byte(8'h5A, 1'b1);
        // top byte value, \u0000, and the highest code point a pair can give
        send_byte(jsu_pkg::CH_QUOTE);
        send_byte(8'hFF);
        send_unit(16'h0000);
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        send_byte(jsu_pkg::CH_QUOTE);
        // control byte in the body
        send_byte(jsu_pkg::CH_QUOTE);
        send_byte(8'h1F);
        // end of data right after \u
        send_byte(jsu_pkg::CH_QUOTE);
        send_byte(jsu_pkg::CH_BSL);
        send_byte(jsu_pkg::CH_LC_U);
        send_byte(8'hA5, 1'b1);
        wait_drained();
    endtask

    // random strings with idling on both sides, pausing now and then
    task automatic test_random_strings();
        int stop_at;
        int strings;
        gaps_on = 1'b1;
        stop_at = bytes_sent + RANDOM_BYTES;
        strings = 0;
        while (bytes_sent < stop_at) begin
            send_random_string();
            strings++;
            if (strings % 40 == 0) wait_drained();
        end
        wait_drained();
    endtask

    // a stretch with no idling at all
    task automatic test_back_to_back();
        int stop_at;
        gaps_on = 1'b0;
        stop_at = bytes_sent + FLOOD_BYTES;
        while (bytes_sent < stop_at) send_random_string();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // receiver holds off while multi-byte escapes keep coming
    task automatic test_receiver_hold();
        int stop_at;
        gaps_on = 1'b0;
        rx_hold = HOLD_CYCLES;
        stop_at = bytes_sent + 40;
        send_byte(jsu_pkg::CH_QUOTE);
        while (bytes_sent < stop_at) send_unit({4'hE, 12'($urandom)});
        send_byte(jsu_pkg::CH_QUOTE);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // result side ready: long hold, random gaps, or ready
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            i_m_tready <= 1'b0;
            rx_gap--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_decoded want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result with nothing expected", o_m_tdata, 0);
            end else begin
                want = decoded_q.pop_front();
                if (o_m_tdata !== want.data)
                    report_mismatch("out_byte", o_m_tdata, want.data);
                if (o_m_tuser[0] !== want.has_byte)
                    report_mismatch("has_byte", o_m_tuser[0], want.has_byte);
                if (o_m_tuser[3:1] !== want.status)
                    report_mismatch("status", o_m_tuser[3:1], want.status);
                if (o_m_tlast !== want.last)
                    report_mismatch("last", o_m_tlast, want.last);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("json_string_unescape_utf8_tb: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 8'h00;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        gaps_on = 1'b1;
        rx_hold = 0;
        rx_gap = 0;
        error_count = 0;
        bytes_sent = 0;
        cycle_count = 0;
        dec_phase = jsu_pkg::PH_QUOTE;
        dec_hex = '0;
        dec_digits = '0;
        dec_hi_sur = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_strings();
        test_back_to_back();
        test_receiver_hold();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("json_string_unescape_utf8_tb: clean");
        end else begin
            $display("json_string_unescape_utf8_tb: errors");
        end
        $finish;
    end

endmodule

/* json_string_unescape_utf8.f */
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_tb.sv
